// ===== src/overwrite_ring_fifo_with_peek_top_assert.svh =====
// Assertion macros used by the checker file of the ring FIFO.
`ifndef OVERWRITE_RING_FIFO_WITH_PEEK_TOP_ASSERT_SVH
`define OVERWRITE_RING_FIFO_WITH_PEEK_TOP_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define ORFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ORFP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/orfp_pkg.sv =====
// Package with sizes, operation codes and interface structs of the ring FIFO.
`timescale 1ns / 1ps
package orfp_pkg;

  localparam int DEPTH = 256;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BYTE_W = 8;
  localparam int OFS_W = 8;
  localparam int SUM_W = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;
  localparam int CMP_W = (CNT_W > OFS_W) ? CNT_W : OFS_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PEEK  = 2'd2
  } op_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             done;
    logic             valid;
    logic             dropped;
    logic [CNT_W-1:0] fill;
  } res_t;

endpackage

// ===== src/orfp_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module orfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/orfp_ctrl.sv =====
// Pointer, count and operation control of the ring FIFO.
`timescale 1ns / 1ps
module orfp_ctrl
  import orfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [BYTE_W-1:0] write_byte,
  input  logic [OFS_W-1:0]  peek_offset,
  output mem_req_t          mem_req,
  output res_t              res
);

  logic [PTR_W-1:0] wptr, wptr_next;
  logic [PTR_W-1:0] rptr, rptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             valid_next, dropped_next;
  logic             full, empty, peek_hit;
  logic [SUM_W-1:0] pos_sum;
  logic [PTR_W-1:0] peek_pos;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign peek_hit = (CMP_W'(peek_offset) < CMP_W'(count));

  // A hit keeps the offset below the depth, so one subtract wraps the sum.
  always_comb begin
    pos_sum = SUM_W'(rptr) + SUM_W'(peek_offset);
    if (pos_sum >= SUM_W'(DEPTH)) begin
      pos_sum = pos_sum - SUM_W'(DEPTH);
    end
    peek_pos = pos_sum[PTR_W-1:0];
  end

  always_comb begin
    wptr_next    = wptr;
    rptr_next    = rptr;
    count_next   = count;
    valid_next   = 1'b0;
    dropped_next = 1'b0;
    mem_req      = '{we: 1'b0, re: 1'b0, addr: rptr, wdata: write_byte};
    if (accept) begin
      case (operation)
        OP_WRITE: begin
          mem_req.we   = 1'b1;
          mem_req.addr = wptr;
          wptr_next    = advance(wptr);
          if (full) begin
            rptr_next    = advance(rptr);
            dropped_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
        end
        OP_READ: begin
          if (!empty) begin
            mem_req.re = 1'b1;
            valid_next = 1'b1;
            rptr_next  = advance(rptr);
            count_next = count - 1'b1;
          end
        end
        OP_PEEK: begin
          if (peek_hit) begin
            mem_req.re   = 1'b1;
            mem_req.addr = peek_pos;
            valid_next   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      count    <= '0;
      res.done <= 1'b0;
    end else begin
      wptr     <= wptr_next;
      rptr     <= rptr_next;
      count    <= count_next;
      res.done <= accept;
    end
    if (accept) begin
      res.valid   <= valid_next;
      res.dropped <= dropped_next;
      res.fill    <= count_next;
    end
  end

endmodule

// ===== src/overwrite_ring_fifo_with_peek_top.sv =====
// Top level of the overwrite-oldest byte ring FIFO with peek.
//
//   Channel   Handshake             Signals
//   command   start high, busy low  operation, write_byte, peek_offset
//   result    done strobe, 1 cycle  read_byte, read_valid, dropped_oldest, fill_count
//
// A command is taken at a clock edge and its result shows on the cycle after, so a new
// command can follow every cycle while busy is low. The single memory port sets this
// figure: a write or a read goes to the byte store at the accepting edge and read data
// is registered. Reset is synchronous; busy is high while rst is high. The receiver
// cannot stall: each result is there for exactly the one cycle that done is high.
`timescale 1ns / 1ps
module overwrite_ring_fifo_with_peek_top
  import orfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation,
  input  logic [BYTE_W-1:0] write_byte,
  input  logic [OFS_W-1:0]  peek_offset,
  output logic              done,
  output logic [BYTE_W-1:0] read_byte,
  output logic              read_valid,
  output logic              dropped_oldest,
  output logic [CNT_W-1:0]  fill_count
);

  logic              accept;
  mem_req_t          mem_req;
  res_t              res;
  logic [BYTE_W-1:0] ram_rdata;

  assign busy   = rst;
  assign accept = start && !busy;

  orfp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (operation),
    .write_byte  (write_byte),
    .peek_offset (peek_offset),
    .mem_req     (mem_req),
    .res         (res)
  );

  orfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (ram_rdata)
  );

  assign done           = res.done;
  assign read_valid     = res.valid;
  assign dropped_oldest = res.dropped;
  assign fill_count     = res.fill;
  assign read_byte      = res.valid ? ram_rdata : '0;

endmodule

// ===== src/orfp_checker.sv =====
// Port-level checker of the ring FIFO and its bind to the top level.
`timescale 1ns / 1ps
`include "overwrite_ring_fifo_with_peek_top_assert.svh"
module orfp_checker
  import orfp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [BYTE_W-1:0] read_byte,
  input logic              read_valid,
  input logic              dropped_oldest,
  input logic [CNT_W-1:0]  fill_count
);

  // Every transfer in gives exactly one result on the next cycle.
  `ORFP_ASSERT(a_done_follows, (start && !busy) |=> done,
               "accepted command gave no result")
  `ORFP_ASSERT(a_done_caused, done |-> $past(start && !busy),
               "result without a command")
  `ORFP_ASSERT(a_drop_full,
               (done && dropped_oldest) |-> (!read_valid && fill_count == CNT_W'(DEPTH)),
               "drop while not full")
  `ORFP_ASSERT_ALWAYS(a_byte_zero, (done && !read_valid) |-> (read_byte == '0),
                      "byte without a hit")

endmodule

bind overwrite_ring_fifo_with_peek_top orfp_checker u_orfp_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .read_byte      (read_byte),
  .read_valid     (read_valid),
  .dropped_oldest (dropped_oldest),
  .fill_count     (fill_count)
);
